@@ hw/rtl/vdsc_pkg.sv @@
// Package for the vehicle drive state controller: state codes and constants.
`timescale 1ns / 1ps

package vdsc_pkg;

  // Vehicle state codes, as seen on the vehicle_state output
  typedef enum logic [2:0] {
    ST_NOT_ACTIVE  = 3'd0,
    ST_ACTIVE      = 3'd1,
    ST_RTD         = 3'd2,
    ST_WANT_PEDAL  = 3'd3,
    ST_WANT_STEER  = 3'd4,
    ST_RECAL_PEDAL = 3'd5,
    ST_RECAL_STEER = 3'd6,
    ST_ERROR       = 3'd7
  } vdsc_state_e;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned HoldW     = 16;
  localparam logic [HoldW-1:0] RecalHoldReset = 16'd3000;

  // One tick of status flags
  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             drive_not_connected;
    logic             drive_faulted;
    logic             hv_latched;
    logic             pedal_recal_button;
    logic             steer_recal_button;
    logic             rtd_button;
    logic             brake_pressed;
    logic             pedal_hb_timeout;
    logic             steer_hb_timeout;
  } vdsc_tick_t;

  // Result of one tick
  typedef struct packed {
    vdsc_state_e vehicle_state;
    logic        drive_cmd_issue;
    logic        drive_cmd_enable;
    logic        motors_idle_cmd;
    logic        send_pedal_recal;
    logic        send_steer_recal;
    logic        start_buzzer;
    logic        reset_heartbeats;
  } vdsc_result_t;

endpackage

@@ hw/rtl/vehicle_drive_state_controller.sv @@
// Vehicle drive state controller: eight-state safety controller, one tick per transfer.
`timescale 1ns / 1ps

// Each accepted tick (timestamp plus status flags) produces exactly one result: the
// vehicle state after the tick and the one-tick command pulses. The tick is captured
// in an input register and resolved on its way into the result register by one state
// decode and a 32-bit wrapping subtract and compare per recalibrate button. The result
// waits in the result register until it transfers out. The error state is absorbing
// until reset. The block accepts a new tick every cycle while the result side keeps up.
// A recalibrate button must be held for strictly more than recal_hold_ms milliseconds
// (reset 3000) before recalibration starts. The user writes the hold time through
// cfg_we_i/cfg_wdata_i while no tick is in flight; the block does not enforce this.
module vehicle_drive_state_controller
  import vdsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [HoldW-1:0] cfg_wdata_i,
  // tick input
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             drive_not_connected_i,
  input  logic             drive_faulted_i,
  input  logic             hv_latched_i,
  input  logic             pedal_recal_button_i,
  input  logic             steer_recal_button_i,
  input  logic             rtd_button_i,
  input  logic             brake_pressed_i,
  input  logic             pedal_hb_timeout_i,
  input  logic             steer_hb_timeout_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       vehicle_state_o,
  output logic             drive_cmd_issue_o,
  output logic             drive_cmd_enable_o,
  output logic             motors_idle_cmd_o,
  output logic             send_pedal_recal_o,
  output logic             send_steer_recal_o,
  output logic             start_buzzer_o,
  output logic             reset_heartbeats_o
);

  logic [HoldW-1:0] hold_q;
  vdsc_state_e      state_q, state_d;
  logic [TimeW-1:0] pedal_start_q, pedal_start_d;
  logic [TimeW-1:0] steer_start_q, steer_start_d;

  logic             in_valid_q;
  vdsc_tick_t       tick_q;
  logic             out_valid_q;
  vdsc_result_t     res_q, res_d;

  logic             fire;
  logic             pedal_held, steer_held;
  logic [TimeW-1:0] pedal_elapsed, steer_elapsed;

  // Tick resolves when the result register is free or being drained
  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;

  // Hold time register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= RecalHoldReset;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q <= '{now_ms:              now_ms_i,
                  drive_not_connected: drive_not_connected_i,
                  drive_faulted:       drive_faulted_i,
                  hv_latched:          hv_latched_i,
                  pedal_recal_button:  pedal_recal_button_i,
                  steer_recal_button:  steer_recal_button_i,
                  rtd_button:          rtd_button_i,
                  brake_pressed:       brake_pressed_i,
                  pedal_hb_timeout:    pedal_hb_timeout_i,
                  steer_hb_timeout:    steer_hb_timeout_i};
    end
  end

  // Hold tests, wrapping elapsed time
  assign pedal_elapsed = tick_q.now_ms - pedal_start_q;
  assign steer_elapsed = tick_q.now_ms - steer_start_q;
  assign pedal_held    = pedal_elapsed > {{(TimeW-HoldW){1'b0}}, hold_q};
  assign steer_held    = steer_elapsed > {{(TimeW-HoldW){1'b0}}, hold_q};

  // Next state and pulses
  always_comb begin
    state_d       = state_q;
    pedal_start_d = pedal_start_q;
    steer_start_d = steer_start_q;
    res_d         = '0;

    unique case (state_q)
      ST_NOT_ACTIVE: begin
        if (tick_q.drive_not_connected) begin
          state_d = ST_ERROR;
        end else if (tick_q.drive_faulted) begin
          state_d = ST_NOT_ACTIVE;
        end else if (tick_q.hv_latched) begin
          state_d = ST_ACTIVE;
        end else if (tick_q.pedal_recal_button) begin
          state_d       = ST_WANT_PEDAL;
          pedal_start_d = tick_q.now_ms;
        end else if (tick_q.steer_recal_button) begin
          state_d       = ST_WANT_STEER;
          steer_start_d = tick_q.now_ms;
        end else begin
          res_d.motors_idle_cmd = 1'b1;
          res_d.drive_cmd_issue = 1'b1;
        end
      end
      ST_ACTIVE: begin
        if (tick_q.drive_not_connected) begin
          state_d = ST_ERROR;
        end else if (tick_q.drive_faulted) begin
          state_d = ST_ACTIVE;
        end else if (!tick_q.hv_latched) begin
          state_d = ST_NOT_ACTIVE;
        end else if (tick_q.rtd_button && tick_q.brake_pressed) begin
          state_d                = ST_RTD;
          res_d.start_buzzer     = 1'b1;
          res_d.reset_heartbeats = 1'b1;
        end
      end
      ST_RTD: begin
        res_d.drive_cmd_issue  = 1'b1;
        res_d.drive_cmd_enable = 1'b1;
        if (tick_q.drive_not_connected) begin
          state_d = ST_ERROR;
        end else if (tick_q.drive_faulted) begin
          state_d = ST_ACTIVE;
        end else if (!tick_q.hv_latched) begin
          state_d = ST_NOT_ACTIVE;
        end else if (tick_q.pedal_hb_timeout || tick_q.steer_hb_timeout) begin
          state_d = ST_ACTIVE;
        end
      end
      ST_WANT_PEDAL: begin
        if (tick_q.drive_not_connected) begin
          state_d       = ST_ERROR;
          pedal_start_d = '0;
        end else begin
          res_d.drive_cmd_issue = 1'b1;
          if (!tick_q.pedal_recal_button) begin
            state_d       = ST_NOT_ACTIVE;
            pedal_start_d = '0;
          end else if (pedal_held) begin
            state_d       = ST_RECAL_PEDAL;
            pedal_start_d = '0;
          end
        end
      end
      ST_WANT_STEER: begin
        // link loss is not checked here
        res_d.drive_cmd_issue = 1'b1;
        if (!tick_q.steer_recal_button) begin
          state_d       = ST_NOT_ACTIVE;
          steer_start_d = '0;
        end else if (steer_held) begin
          state_d       = ST_RECAL_STEER;
          steer_start_d = '0;
        end
      end
      ST_RECAL_PEDAL: begin
        res_d.drive_cmd_issue = 1'b1;
        if (!tick_q.pedal_recal_button) begin
          state_d       = ST_NOT_ACTIVE;
          pedal_start_d = '0;
        end else begin
          res_d.send_pedal_recal = 1'b1;
        end
      end
      ST_RECAL_STEER: begin
        res_d.drive_cmd_issue = 1'b1;
        if (!tick_q.steer_recal_button) begin
          state_d       = ST_NOT_ACTIVE;
          steer_start_d = '0;
        end else begin
          res_d.send_steer_recal = 1'b1;
        end
      end
      ST_ERROR: begin
        state_d = ST_ERROR;
      end
      default: begin
        state_d = ST_ERROR;
      end
    endcase

    res_d.vehicle_state = state_d;
  end

  // Controller state, advanced once per resolved tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_NOT_ACTIVE;
      pedal_start_q <= '0;
      steer_start_q <= '0;
    end else if (fire) begin
      state_q       <= state_d;
      pedal_start_q <= pedal_start_d;
      steer_start_q <= steer_start_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign vehicle_state_o    = res_q.vehicle_state;
  assign drive_cmd_issue_o  = res_q.drive_cmd_issue;
  assign drive_cmd_enable_o = res_q.drive_cmd_enable;
  assign motors_idle_cmd_o  = res_q.motors_idle_cmd;
  assign send_pedal_recal_o = res_q.send_pedal_recal;
  assign send_steer_recal_o = res_q.send_steer_recal;
  assign start_buzzer_o     = res_q.start_buzzer;
  assign reset_heartbeats_o = res_q.reset_heartbeats;

  // Error is absorbing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ERROR |=> state_q == ST_ERROR)
    else $error("left error state");

  // Enable only rides on an issued command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_cmd_enable_o |-> drive_cmd_issue_o)
    else $error("drive enable without command");

  // Buzzer only on entry into ready to drive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_buzzer_o |-> vehicle_state_o == ST_RTD && reset_heartbeats_o)
    else $error("buzzer outside ready-to-drive entry");

  // A buffered tick is never dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(tick_q))
    else $error("buffered tick lost");

endmodule

@@ sim/vehicle_drive_state_controller_tb.sv @@
// Testbench for the vehicle drive state controller: directed ticks, then random ticks checked
// against a tick-by-tick model of the state machine.
`timescale 1ns / 1ps

module vehicle_drive_state_controller_tb;
  import vdsc_pkg::*;

  localparam int unsigned CycleLimit    = 60000;
  localparam int unsigned RxStallCycles = 60;
  localparam int unsigned PhaseTicks    = 100;
  localparam int unsigned DirN          = 25;

  // Status flag masks, in port order
  localparam logic [8:0] F_NONE  = 9'h000;
  localparam logic [8:0] F_NC    = 9'h100;
  localparam logic [8:0] F_FLT   = 9'h080;
  localparam logic [8:0] F_HV    = 9'h040;
  localparam logic [8:0] F_PBTN  = 9'h020;
  localparam logic [8:0] F_SBTN  = 9'h010;
  localparam logic [8:0] F_RTD   = 9'h008;
  localparam logic [8:0] F_BRAKE = 9'h004;
  localparam logic [8:0] F_PTO   = 9'h002;
  localparam logic [8:0] F_STO   = 9'h001;

  // Result pulse masks, in port order
  localparam logic [6:0] P_NONE  = 7'h00;
  localparam logic [6:0] P_ISSUE = 7'h40;
  localparam logic [6:0] P_EN    = 7'h20;
  localparam logic [6:0] P_IDLE  = 7'h10;
  localparam logic [6:0] P_SPR   = 7'h08;
  localparam logic [6:0] P_SSR   = 7'h04;
  localparam logic [6:0] P_BUZZ  = 7'h02;
  localparam logic [6:0] P_HB    = 7'h01;

  // One directed tick; st and pulses only count where fixed is set
  typedef struct packed {
    logic [31:0] now;
    logic [8:0]  flags;
    logic        fixed;
    logic [2:0]  st;
    logic [6:0]  pulses;
  } stim_row_t;

  // Walk through every state but error from reset, hold boundary at 3000 ms, timestamp wrap
  localparam stim_row_t DirRows [DirN] = '{
    '{32'd0,         F_NONE,                          1'b1, ST_NOT_ACTIVE,  P_ISSUE | P_IDLE},
    '{32'd1,         F_HV | F_FLT,                    1'b1, ST_NOT_ACTIVE,  P_NONE},
    '{32'd2,         F_HV,                            1'b1, ST_ACTIVE,      P_NONE},
    '{32'd3,         F_HV | F_FLT | F_RTD | F_BRAKE,  1'b1, ST_ACTIVE,      P_NONE},
    '{32'd4,         F_HV | F_RTD,                    1'b1, ST_ACTIVE,      P_NONE},
    '{32'd5,         F_HV | F_RTD | F_BRAKE,          1'b1, ST_RTD,         P_BUZZ | P_HB},
    '{32'd6,         F_HV,                            1'b1, ST_RTD,         P_ISSUE | P_EN},
    '{32'd7,         F_HV | F_PTO,                    1'b1, ST_ACTIVE,      P_ISSUE | P_EN},
    '{32'd8,         F_HV | F_RTD | F_BRAKE,          1'b1, ST_RTD,         P_BUZZ | P_HB},
    '{32'd9,         F_HV | F_STO,                    1'b1, ST_ACTIVE,      P_ISSUE | P_EN},
    '{32'd10,        F_HV | F_RTD | F_BRAKE,          1'b1, ST_RTD,         P_BUZZ | P_HB},
    '{32'd11,        F_HV | F_FLT,                    1'b1, ST_ACTIVE,      P_ISSUE | P_EN},
    '{32'd12,        F_HV | F_RTD | F_BRAKE,          1'b1, ST_RTD,         P_BUZZ | P_HB},
    '{32'd13,        F_NONE,                          1'b1, ST_NOT_ACTIVE,  P_ISSUE | P_EN},
    '{32'd100,       F_PBTN | F_SBTN,                 1'b1, ST_WANT_PEDAL,  P_NONE},
    '{32'd3100,      F_PBTN,                          1'b0, ST_NOT_ACTIVE,  P_NONE},
    '{32'd3101,      F_PBTN,                          1'b0, ST_NOT_ACTIVE,  P_NONE},
    '{32'd3102,      F_PBTN | F_RTD | F_BRAKE | F_PTO | F_STO,
                                                      1'b1, ST_RECAL_PEDAL, P_ISSUE | P_SPR},
    '{32'd3103,      F_NONE,                          1'b1, ST_NOT_ACTIVE,  P_ISSUE},
    '{32'hFFFF_FF00, F_SBTN,                          1'b1, ST_WANT_STEER,  P_NONE},
    '{32'h0000_0AB8, F_SBTN | F_NC,                   1'b0, ST_NOT_ACTIVE,  P_NONE},
    '{32'h0000_0AB9, F_SBTN,                          1'b0, ST_NOT_ACTIVE,  P_NONE},
    '{32'h0000_0ABA, F_SBTN | F_NC | F_FLT | F_HV,    1'b1, ST_RECAL_STEER, P_ISSUE | P_SSR},
    '{32'hFFFF_FFFF, F_NONE,                          1'b1, ST_NOT_ACTIVE,  P_ISSUE},
    '{32'hFFFF_FFFF, F_PBTN,                          1'b1, ST_WANT_PEDAL,  P_NONE}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [HoldW-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [TimeW-1:0] now_ms_i = '0;
  logic             drive_not_connected_i = 1'b0;
  logic             drive_faulted_i = 1'b0;
  logic             hv_latched_i = 1'b0;
  logic             pedal_recal_button_i = 1'b0;
  logic             steer_recal_button_i = 1'b0;
  logic             rtd_button_i = 1'b0;
  logic             brake_pressed_i = 1'b0;
  logic             pedal_hb_timeout_i = 1'b0;
  logic             steer_hb_timeout_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [2:0]       vehicle_state_o;
  logic             drive_cmd_issue_o;
  logic             drive_cmd_enable_o;
  logic             motors_idle_cmd_o;
  logic             send_pedal_recal_o;
  logic             send_steer_recal_o;
  logic             start_buzzer_o;
  logic             reset_heartbeats_o;

  // Model copy of the controller state and hold time
  vdsc_state_e      ctl_state = ST_NOT_ACTIVE;
  logic [31:0]      pedal_t0 = '0;
  logic [31:0]      steer_t0 = '0;
  logic [HoldW-1:0] hold_ms = RecalHoldReset;

  vdsc_result_t     tick_results [$];
  int unsigned      accepted_cnt = 0;
  int unsigned      retired_cnt = 0;
  int unsigned      mismatch_cnt = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;
  int unsigned      stall_reqs = 0;
  int unsigned      stall_seen = 0;
  int unsigned      stall_left = 0;
  logic [31:0]      last_now = '0;
  logic             fixed_on = 1'b0;
  stim_row_t        fixed_row;

  vehicle_drive_state_controller DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .now_ms_i              (now_ms_i),
    .drive_not_connected_i (drive_not_connected_i),
    .drive_faulted_i       (drive_faulted_i),
    .hv_latched_i          (hv_latched_i),
    .pedal_recal_button_i  (pedal_recal_button_i),
    .steer_recal_button_i  (steer_recal_button_i),
    .rtd_button_i          (rtd_button_i),
    .brake_pressed_i       (brake_pressed_i),
    .pedal_hb_timeout_i    (pedal_hb_timeout_i),
    .steer_hb_timeout_i    (steer_hb_timeout_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .vehicle_state_o       (vehicle_state_o),
    .drive_cmd_issue_o     (drive_cmd_issue_o),
    .drive_cmd_enable_o    (drive_cmd_enable_o),
    .motors_idle_cmd_o     (motors_idle_cmd_o),
    .send_pedal_recal_o    (send_pedal_recal_o),
    .send_steer_recal_o    (send_steer_recal_o),
    .start_buzzer_o        (start_buzzer_o),
    .reset_heartbeats_o    (reset_heartbeats_o)
  );

  always #5 clk_i = ~clk_i;

  // State change: clears the wait time of the state left, stamps the one entered
  function automatic void enter_state(vdsc_state_e nxt, logic [31:0] now,
                                      inout vdsc_result_t r);
    if (ctl_state == ST_WANT_PEDAL || ctl_state == ST_RECAL_PEDAL) pedal_t0 = '0;
    if (ctl_state == ST_WANT_STEER || ctl_state == ST_RECAL_STEER) steer_t0 = '0;
    ctl_state = nxt;
    case (nxt)
      ST_RTD: begin
        r.start_buzzer     = 1'b1;
        r.reset_heartbeats = 1'b1;
      end
      ST_WANT_PEDAL: pedal_t0 = now;
      ST_WANT_STEER: steer_t0 = now;
      default: ;
    endcase
  endfunction

  // Advance the model by one tick and return the result it should produce
  function automatic vdsc_result_t step_controller(vdsc_tick_t t);
    vdsc_result_t r;
    r = '0;
    case (ctl_state)
      ST_NOT_ACTIVE: begin
        if (t.drive_not_connected) enter_state(ST_ERROR, t.now_ms, r);
        else if (t.drive_faulted) ;
        else if (t.hv_latched) enter_state(ST_ACTIVE, t.now_ms, r);
        else if (t.pedal_recal_button) enter_state(ST_WANT_PEDAL, t.now_ms, r);
        else if (t.steer_recal_button) enter_state(ST_WANT_STEER, t.now_ms, r);
        else begin
          r.motors_idle_cmd = 1'b1;
          r.drive_cmd_issue = 1'b1;
        end
      end
      ST_ACTIVE: begin
        if (t.drive_not_connected) enter_state(ST_ERROR, t.now_ms, r);
        else if (t.drive_faulted) ;
        else if (!t.hv_latched) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
        else if (t.rtd_button && t.brake_pressed) enter_state(ST_RTD, t.now_ms, r);
      end
      ST_RTD: begin
        r.drive_cmd_issue  = 1'b1;
        r.drive_cmd_enable = 1'b1;
        if (t.drive_not_connected) enter_state(ST_ERROR, t.now_ms, r);
        else if (t.drive_faulted) enter_state(ST_ACTIVE, t.now_ms, r);
        else if (!t.hv_latched) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
        else if (t.pedal_hb_timeout || t.steer_hb_timeout) enter_state(ST_ACTIVE, t.now_ms, r);
      end
      ST_WANT_PEDAL: begin
        // lost link here goes to error without a command
        if (t.drive_not_connected) enter_state(ST_ERROR, t.now_ms, r);
        else begin
          r.drive_cmd_issue = 1'b1;
          if (!t.pedal_recal_button) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
          else if (t.now_ms - pedal_t0 > 32'(hold_ms))
            enter_state(ST_RECAL_PEDAL, t.now_ms, r);
        end
      end
      ST_WANT_STEER: begin
        r.drive_cmd_issue = 1'b1;
        if (!t.steer_recal_button) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
        else if (t.now_ms - steer_t0 > 32'(hold_ms))
          enter_state(ST_RECAL_STEER, t.now_ms, r);
      end
      ST_RECAL_PEDAL: begin
        r.drive_cmd_issue = 1'b1;
        if (!t.pedal_recal_button) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
        else r.send_pedal_recal = 1'b1;
      end
      ST_RECAL_STEER: begin
        r.drive_cmd_issue = 1'b1;
        if (!t.steer_recal_button) enter_state(ST_NOT_ACTIVE, t.now_ms, r);
        else r.send_steer_recal = 1'b1;
      end
      default: ;
    endcase
    r.vehicle_state = ctl_state;
    return r;
  endfunction

  // Random tick, biased per state so that most ticks move the controller forward
  function automatic vdsc_tick_t make_tick();
    vdsc_tick_t  t;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) t.now_ms = $urandom();
    else t.now_ms = last_now + 32'($urandom_range(0, int'(hold_ms) / 4 + 3));
    t.drive_not_connected = 1'b0;
    t.drive_faulted       = ($urandom_range(0, 99) < 10);
    t.hv_latched          = ($urandom_range(0, 99) < 70);
    t.pedal_recal_button  = 1'($urandom_range(0, 1));
    t.steer_recal_button  = 1'($urandom_range(0, 1));
    t.rtd_button          = 1'($urandom_range(0, 1));
    t.brake_pressed       = 1'($urandom_range(0, 1));
    t.pedal_hb_timeout    = ($urandom_range(0, 99) < 15);
    t.steer_hb_timeout    = ($urandom_range(0, 99) < 15);
    pick = $urandom_range(0, 99);
    case (ctl_state)
      ST_NOT_ACTIVE: begin
        if (pick < 88) t.drive_faulted = 1'b0;
        if (pick < 30) t.hv_latched = 1'b1;
        else if (pick < 88) begin
          t.hv_latched         = 1'b0;
          t.pedal_recal_button = (pick < 55);
          t.steer_recal_button = (pick < 78);
        end
      end
      ST_ACTIVE: begin
        if (pick < 50) begin
          t.drive_faulted = 1'b0;
          t.hv_latched    = 1'b1;
          t.rtd_button    = 1'b1;
          t.brake_pressed = 1'b1;
        end
      end
      ST_RTD: begin
        if (pick < 60) begin
          t.drive_faulted    = 1'b0;
          t.hv_latched       = 1'b1;
          t.pedal_hb_timeout = 1'b0;
          t.steer_hb_timeout = 1'b0;
        end
      end
      ST_WANT_PEDAL: begin
        t.pedal_recal_button = (pick < 92);
        // land on the hold boundary, or one past it
        if ($urandom_range(0, 99) < 40)
          t.now_ms = pedal_t0 + 32'(hold_ms) + 32'($urandom_range(0, 1));
      end
      ST_WANT_STEER: begin
        t.steer_recal_button  = (pick < 92);
        t.drive_not_connected = ($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 40)
          t.now_ms = steer_t0 + 32'(hold_ms) + 32'($urandom_range(0, 1));
      end
      ST_RECAL_PEDAL: begin
        t.pedal_recal_button  = (pick < 85);
        t.drive_not_connected = ($urandom_range(0, 99) < 30);
      end
      ST_RECAL_STEER: begin
        t.steer_recal_button  = (pick < 85);
        t.drive_not_connected = ($urandom_range(0, 99) < 30);
      end
      default: ;
    endcase
    last_now = t.now_ms;
    return t;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Offer one tick, with an optional gap first, and wait for its transfer
  task automatic send_tick(vdsc_tick_t t);
    int unsigned target;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    now_ms_i              <= t.now_ms;
    drive_not_connected_i <= t.drive_not_connected;
    drive_faulted_i       <= t.drive_faulted;
    hv_latched_i          <= t.hv_latched;
    pedal_recal_button_i  <= t.pedal_recal_button;
    steer_recal_button_i  <= t.steer_recal_button;
    rtd_button_i          <= t.rtd_button;
    brake_pressed_i       <= t.brake_pressed;
    pedal_hb_timeout_i    <= t.pedal_hb_timeout;
    steer_hb_timeout_i    <= t.steer_hb_timeout;
    in_valid_i            <= 1'b1;
    target = accepted_cnt + 1;
    wait (accepted_cnt == target);
  endtask

  // Hold time is only written with nothing in flight
  task automatic write_hold(logic [HoldW-1:0] v);
    in_valid_i <= 1'b0;
    wait (retired_cnt == accepted_cnt);
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Transfer monitor: model update on input, check on output
  always @(posedge clk_i) begin
    vdsc_result_t want;
    vdsc_result_t modelled;
    if (rst_ni) begin
      if (cfg_we_i) hold_ms = cfg_wdata_i;
      if (in_valid_i && in_ready_o) begin
        modelled = step_controller(vdsc_tick_t'({now_ms_i, drive_not_connected_i,
            drive_faulted_i, hv_latched_i, pedal_recal_button_i, steer_recal_button_i,
            rtd_button_i, brake_pressed_i, pedal_hb_timeout_i, steer_hb_timeout_i}));
        if (fixed_on) begin
          want.vehicle_state = vdsc_state_e'(fixed_row.st);
          {want.drive_cmd_issue, want.drive_cmd_enable, want.motors_idle_cmd,
           want.send_pedal_recal, want.send_steer_recal, want.start_buzzer,
           want.reset_heartbeats} = fixed_row.pulses;
          tick_results.push_back(want);
        end else begin
          tick_results.push_back(modelled);
        end
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (tick_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatch_cnt++;
        end else begin
          want = tick_results.pop_front();
          check_field("vehicle_state", want.vehicle_state, vehicle_state_o);
          check_field("drive_cmd_issue", want.drive_cmd_issue, drive_cmd_issue_o);
          check_field("drive_cmd_enable", want.drive_cmd_enable, drive_cmd_enable_o);
          check_field("motors_idle_cmd", want.motors_idle_cmd, motors_idle_cmd_o);
          check_field("send_pedal_recal", want.send_pedal_recal, send_pedal_recal_o);
          check_field("send_steer_recal", want.send_steer_recal, send_steer_recal_o);
          check_field("start_buzzer", want.start_buzzer, start_buzzer_o);
          check_field("reset_heartbeats", want.reset_heartbeats, reset_heartbeats_o);
          retired_cnt++;
        end
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_seen != stall_reqs) begin
      stall_seen  <= stall_reqs;
      stall_left  <= RxStallCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("vehicle_drive_state_controller_tb failed");
      $finish;
    end
  end

  initial begin
    logic [HoldW-1:0] phase_hold [4];
    vdsc_tick_t       t;
    phase_hold[0] = '0;
    phase_hold[1] = '1;
    phase_hold[2] = HoldW'($urandom_range(1, 5000));
    phase_hold[3] = RecalHoldReset;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks on reset hold time
    tx_idle_pct = 12;
    rx_idle_pct = 62;
    for (int i = 0; i < DirN; i++) begin
      fixed_on  = DirRows[i].fixed;
      fixed_row = DirRows[i];
      send_tick(vdsc_tick_t'({DirRows[i].now, DirRows[i].flags}));
    end
    fixed_on = 1'b0;
    last_now = DirRows[DirN-1].now;

    // Random phases, each on its own hold time, the last two without idle gaps
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 62 : 0;
      rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 12 : 0;
      write_hold(phase_hold[ph]);
      for (int n = 0; n < PhaseTicks; n++) begin
        if (ph == 2 && n == 20) stall_reqs++;
        send_tick(make_tick());
      end
    end

    // Lose the inverter link until the controller locks up, then a few more ticks
    while (ctl_state != ST_ERROR) begin
      t = make_tick();
      t.drive_not_connected = 1'b1;
      send_tick(t);
    end
    repeat (8) send_tick(make_tick());

    in_valid_i <= 1'b0;
    wait (retired_cnt == accepted_cnt);
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("vehicle_drive_state_controller_tb passed");
    end else begin
      $display("vehicle_drive_state_controller_tb failed");
    end
    $finish;
  end

endmodule
